// File: sv/fume_fan_mode_controller_unit_defines.svh
// Assertion macros used by the fan mode controller RTL (ffmc_mode).
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef FUME_FAN_MODE_CONTROLLER_UNIT_DEFINES_SVH
`define FUME_FAN_MODE_CONTROLLER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define FFMC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ffmc: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define FFMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ffmc: next-cycle check failed");

`else

`define FFMC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define FFMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/ffmc_pkg.sv
// Package of the fan mode controller: codes, debouncer constants and the
// configuration and result structs. No dependencies.
package ffmc_pkg;

    localparam logic [15:0] DEB_MASK    = 16'hE000;
    localparam logic [15:0] DEB_PATTERN = 16'hF000;

    localparam logic [1:0] MODE_READY   = 2'd0;
    localparam logic [1:0] MODE_LOW     = 2'd1;
    localparam logic [1:0] MODE_HIGH    = 2'd2;
    localparam logic [1:0] MODE_RESTART = 2'd3;

    localparam logic [1:0] FAN_OFF  = 2'd0;
    localparam logic [1:0] FAN_LOW  = 2'd1;
    localparam logic [1:0] FAN_FULL = 2'd2;

    localparam logic [1:0] CFG_TVOC_THRESHOLD  = 2'd0;
    localparam logic [1:0] CFG_EXTRACT_SECONDS = 2'd1;
    localparam logic [1:0] CFG_POLL_PERIOD_MS  = 2'd2;
    localparam logic [1:0] CFG_BUTTON_SAMPLE   = 2'd3;

    localparam logic [15:0] RST_TVOC_THRESHOLD  = 16'd60;
    localparam logic [15:0] RST_EXTRACT_SECONDS = 16'd10;
    localparam logic [15:0] RST_POLL_PERIOD_MS  = 16'd1000;
    localparam logic [7:0]  RST_BUTTON_SAMPLE   = 8'd5;

    typedef struct packed {
        logic [15:0] tvoc_threshold;
        logic [15:0] extract_seconds;
        logic [15:0] poll_period_ms;
        logic [7:0]  button_sample_ms;
    } t_cfg;

    typedef struct packed {
        logic       poll_taken;
        logic [1:0] mode;
        logic [1:0] fan_speed;
    } t_result;

endpackage

// File: sv/ffmc_debounce.sv
// Button sample divider and 16-bit shift debouncer of the fan controller.
// Depends on ffmc_pkg.
module ffmc_debounce (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_level,
    input  logic [7:0] i_sample_ms,
    output logic       o_confirm
);
    import ffmc_pkg::*;

    logic [7:0]  r_div;
    logic [7:0]  n_div;
    logic [15:0] r_hist;
    logic [15:0] n_hist;
    logic [7:0]  div_inc;
    logic        sample;

    always_comb begin
        div_inc = r_div + 8'd1;
        // A count of zero (wrap or zero period) also samples.
        sample  = (div_inc >= i_sample_ms) || (div_inc == 8'd0);
        n_div   = sample ? 8'd0 : div_inc;
        // History holds inverted levels, so a press shifts in zeros.
        n_hist  = sample ? ({r_hist[14:0], ~i_level} | DEB_MASK) : r_hist;
        o_confirm = sample && (n_hist == DEB_PATTERN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div  <= 8'd0;
            r_hist <= 16'd0;
        end else if (i_step) begin
            r_div  <= n_div;
            r_hist <= n_hist;
        end
    end

endmodule

// File: sv/ffmc_mode.sv
// Mode state machine of the fan controller: poll timing, press latch,
// fume seconds and fan drive. Depends on ffmc_pkg and the defines header.
`include "fume_fan_mode_controller_unit_defines.svh"

module ffmc_mode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_confirm,
    input  logic [15:0]       i_tvoc,
    input  ffmc_pkg::t_cfg    i_cfg,
    output ffmc_pkg::t_result o_result
);
    import ffmc_pkg::*;

    // Ticks since the last poll, kept modulo 2^32.
    logic [31:0] r_since;
    logic [31:0] n_since;
    logic        r_press;
    logic        n_press;
    logic [1:0]  r_mode;
    logic [1:0]  n_mode;
    logic [1:0]  r_fan;
    logic [1:0]  n_fan;
    logic [15:0] r_fs;
    logic [15:0] n_fs;

    logic [31:0] since_inc;
    logic        poll_due;
    logic        press;
    logic        polled;
    logic [15:0] fs_base;

    always_comb begin
        since_inc = r_since + 32'd1;
        poll_due  = since_inc >= {16'd0, i_cfg.poll_period_ms};
        press     = r_press | i_confirm;
        n_since   = since_inc;
        n_press   = press;
        n_mode    = r_mode;
        n_fan     = r_fan;
        n_fs      = r_fs;
        fs_base   = r_fs;
        polled    = 1'b0;
        case (r_mode)
            MODE_READY: begin
                if (press) begin
                    n_press = 1'b0;
                    n_fan   = FAN_LOW;
                    n_mode  = MODE_LOW;
                end
            end
            MODE_LOW: begin
                if (poll_due) begin
                    polled  = 1'b1;
                    n_since = 32'd0;
                    if (i_tvoc > i_cfg.tvoc_threshold) begin
                        n_fan  = FAN_FULL;
                        n_mode = MODE_HIGH;
                    end
                end
                if (press) begin
                    n_press = 1'b0;
                    n_mode  = MODE_RESTART;
                end
            end
            MODE_HIGH: begin
                if (poll_due) begin
                    polled  = 1'b1;
                    n_since = 32'd0;
                    if ((i_tvoc < i_cfg.tvoc_threshold) &&
                        (r_fs >= i_cfg.extract_seconds)) begin
                        n_fan   = FAN_LOW;
                        n_mode  = MODE_LOW;
                        fs_base = 16'd0;
                    end
                    // The count still advances right after the clear.
                    n_fs = (fs_base == 16'hFFFF) ? fs_base : fs_base + 16'd1;
                end
                if (press) begin
                    n_fs    = 16'd0;
                    n_press = 1'b0;
                    n_mode  = MODE_RESTART;
                end
            end
            default: begin
                n_fan  = FAN_OFF;
                n_mode = MODE_READY;
            end
        endcase
        o_result.fan_speed  = n_fan;
        o_result.mode       = n_mode;
        o_result.poll_taken = polled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= 32'd0;
            r_press <= 1'b0;
            r_mode  <= MODE_READY;
            r_fan   <= FAN_OFF;
            r_fs    <= 16'd0;
        end else if (i_step) begin
            r_since <= n_since;
            r_press <= n_press;
            r_mode  <= n_mode;
            r_fan   <= n_fan;
            r_fs    <= n_fs;
        end
    end

    `FFMC_ASSERT_IMPLY(a_ready_fan_off, i_clk, i_rst_n, r_mode == MODE_READY, r_fan == FAN_OFF)
    `FFMC_ASSERT_IMPLY(a_high_fan_only_high_or_restart, i_clk, i_rst_n, r_fan == FAN_FULL, (r_mode == MODE_HIGH) || (r_mode == MODE_RESTART))
    `FFMC_ASSERT_NEXT(a_restart_goes_ready, i_clk, i_rst_n, i_step && (r_mode == MODE_RESTART), (r_mode == MODE_READY) && (r_fan == FAN_OFF))
    `FFMC_ASSERT_IMPLY(a_poll_only_running, i_clk, i_rst_n, polled, (r_mode == MODE_LOW) || (r_mode == MODE_HIGH))
    `FFMC_ASSERT_NEXT(a_press_consumed_in_ready, i_clk, i_rst_n, i_step && (r_mode == MODE_READY) && press, !r_press && (r_mode == MODE_LOW))

endmodule

// File: sv/fume_fan_mode_controller_unit.sv
// Top level of the fume extractor fan mode controller: stream ports,
// input and result registers, configuration registers.
// Depends on ffmc_pkg, ffmc_debounce and ffmc_mode.
//
// Usage: each transaction on the slave stream is one millisecond tick that
// carries the raw button level and the current TVOC reading. For every
// tick exactly one result transaction leaves on the master stream with the
// fan drive, the mode and a flag that says whether the sensor was polled.
// The tick is captured in an input register; when the pipeline advances, the
// debouncer and the mode machine update their state from it in one short
// combinational pass and the result lands in the output register. A result
// is offered once its tick has moved on from the input register; while the
// receiver keeps up a new tick is accepted in every cycle; the sustained rate
// of one tick per cycle is set by the single state update per tick in ffmc_mode.
// When the receiver stalls, the output register holds its result, the
// input register still takes one more tick, and after that s_axis_tready
// drops until the result is taken; nothing is lost or repeated.
// Configuration registers are written through i_cfg_we, i_cfg_index and i_cfg_data,
// one register per cycle, only while no tick is in flight (a user rule, not enforced).
// Synchronous reset (i_rst_n low) empties both registers, clears all
// state to ready mode with the fan stopped and restores the register
// defaults: threshold 60 ppb, 10 extract polls, 1000 ms poll period and
// 5 ms button sample period.
module fume_fan_mode_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Tick stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [0] button_level, [16:1] tvoc_ppb, rest zero
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // [1:0] fan_speed, [3:2] mode, [4] poll_taken
);
    import ffmc_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic        r_in_level;
    logic [15:0] r_in_tvoc;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        advance;
    logic        step;
    logic        confirm;

    // The pipeline moves whenever the output register is free or drained.
    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tvoc_threshold   <= RST_TVOC_THRESHOLD;
            r_cfg.extract_seconds  <= RST_EXTRACT_SECONDS;
            r_cfg.poll_period_ms   <= RST_POLL_PERIOD_MS;
            r_cfg.button_sample_ms <= RST_BUTTON_SAMPLE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TVOC_THRESHOLD:  r_cfg.tvoc_threshold   <= i_cfg_data;
                CFG_EXTRACT_SECONDS: r_cfg.extract_seconds  <= i_cfg_data;
                CFG_POLL_PERIOD_MS:  r_cfg.poll_period_ms   <= i_cfg_data;
                CFG_BUTTON_SAMPLE:   r_cfg.button_sample_ms <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_level <= s_axis_tdata[0];
            r_in_tvoc  <= s_axis_tdata[16:1];
        end
    end

    ffmc_debounce u_debounce (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_level     (r_in_level),
        .i_sample_ms (r_cfg.button_sample_ms),
        .o_confirm   (confirm)
    );

    ffmc_mode u_mode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_confirm (confirm),
        .i_tvoc    (r_in_tvoc),
        .i_cfg     (r_cfg),
        .o_result  (n_out)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out.poll_taken, r_out.mode, r_out.fan_speed};

endmodule

// File: sim/ffmc_checker.sv
// Scoreboard for the fan mode controller: watches the configuration port and both
// streams, predicts every result transaction and compares it field by field.
// Depends on ffmc_pkg for the mode, fan and register codes and the structs.
`timescale 1ns / 100ps

module ffmc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    output int          o_pending,
    output int          o_errors
);
    import ffmc_pkg::*;

    t_cfg        regs;
    logic [31:0] tick_cnt;
    logic [31:0] last_poll;
    logic [7:0]  smp_div;
    logic [15:0] deb_hist;
    logic        press_pending;
    logic [1:0]  mode_st;
    logic [1:0]  fan_st;
    logic [15:0] fume_secs;

    t_result     fan_result_q[$];
    int          err_cnt    = 0;
    int          result_idx = 0;

    initial begin
        o_pending = 0;
        o_errors  = 0;
    end

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("ERROR: result %0d, %s: expected %0d, got %0d",
                 result_idx, what, exp_v, got_v);
        err_cnt++;
    endtask

    // One millisecond tick of the controller: debounce, then one mode step.
    function automatic t_result advance_tick(input logic level, input logic [15:0] tvoc);
        t_result res;
        logic    polled;
        polled   = 1'b0;
        tick_cnt = tick_cnt + 32'd1;

        // The divider restarts when it reaches or has passed the period; a zero
        // period therefore samples on every tick.
        smp_div = smp_div + 8'd1;
        if (smp_div >= regs.button_sample_ms || smp_div == 8'd0) begin
            smp_div  = 8'd0;
            deb_hist = {deb_hist[14:0], ~level} | DEB_MASK;
            if (deb_hist == DEB_PATTERN) begin
                press_pending = 1'b1;
            end
        end

        case (mode_st)
            MODE_READY: begin
                if (press_pending) begin
                    press_pending = 1'b0;
                    fan_st        = FAN_LOW;
                    mode_st       = MODE_LOW;
                end
            end
            MODE_LOW: begin
                if (tick_cnt - last_poll >= {16'd0, regs.poll_period_ms}) begin
                    polled = 1'b1;
                    if (tvoc > regs.tvoc_threshold) begin
                        fan_st  = FAN_FULL;
                        mode_st = MODE_HIGH;
                    end
                    last_poll = tick_cnt;
                end
                if (press_pending) begin
                    press_pending = 1'b0;
                    mode_st       = MODE_RESTART;
                end
            end
            MODE_HIGH: begin
                if (tick_cnt - last_poll >= {16'd0, regs.poll_period_ms}) begin
                    polled = 1'b1;
                    if (tvoc < regs.tvoc_threshold && fume_secs >= regs.extract_seconds) begin
                        fan_st    = FAN_LOW;
                        mode_st   = MODE_LOW;
                        fume_secs = 16'd0;
                    end
                    last_poll = tick_cnt;
                    // The count moves on even right after the clear above.
                    if (fume_secs != 16'hFFFF) begin
                        fume_secs = fume_secs + 16'd1;
                    end
                end
                if (press_pending) begin
                    fume_secs     = 16'd0;
                    press_pending = 1'b0;
                    mode_st       = MODE_RESTART;
                end
            end
            default: begin
                // Restart: the fan kept its drive for one tick and stops now.
                fan_st  = FAN_OFF;
                mode_st = MODE_READY;
            end
        endcase

        res.fan_speed  = fan_st;
        res.mode       = mode_st;
        res.poll_taken = polled;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            regs.tvoc_threshold   = RST_TVOC_THRESHOLD;
            regs.extract_seconds  = RST_EXTRACT_SECONDS;
            regs.poll_period_ms   = RST_POLL_PERIOD_MS;
            regs.button_sample_ms = RST_BUTTON_SAMPLE;
            tick_cnt      = 32'd0;
            last_poll     = 32'd0;
            smp_div       = 8'd0;
            deb_hist      = 16'd0;
            press_pending = 1'b0;
            mode_st       = MODE_READY;
            fan_st        = FAN_OFF;
            fume_secs     = 16'd0;
            fan_result_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TVOC_THRESHOLD:  regs.tvoc_threshold   = i_cfg_data;
                    CFG_EXTRACT_SECONDS: regs.extract_seconds  = i_cfg_data;
                    CFG_POLL_PERIOD_MS:  regs.poll_period_ms   = i_cfg_data;
                    CFG_BUTTON_SAMPLE:   regs.button_sample_ms = i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            // A result is never produced in the cycle of its own tick, so the
            // output side is retired before the new tick is predicted.
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[4:0]);
                if (fan_result_q.size() == 0) begin
                    report_mismatch("unexpected result, packed fields", -1, int'(got));
                end else begin
                    want = fan_result_q.pop_front();
                    if (got.fan_speed != want.fan_speed)
                        report_mismatch("fan_speed", want.fan_speed, got.fan_speed);
                    if (got.mode != want.mode)
                        report_mismatch("mode", want.mode, got.mode);
                    if (got.poll_taken != want.poll_taken)
                        report_mismatch("poll_taken", want.poll_taken, got.poll_taken);
                end
                result_idx++;
            end
            if (i_s_tvalid && i_s_tready) begin
                fan_result_q.push_back(advance_tick(i_s_tdata[0], i_s_tdata[16:1]));
            end
        end
        o_pending <= fan_result_q.size();
        o_errors  <= err_cnt;
    end

endmodule

// File: sim/fume_fan_mode_controller_unit_tb.sv
// Testbench top for the fan mode controller: clock, reset, configuration writes,
// tick stimulus with random idling on both streams, and the final verdict.
// Depends on ffmc_pkg, the controller RTL and ffmc_checker.
`timescale 1ns / 100ps

module fume_fan_mode_controller_unit_tb;
    import ffmc_pkg::*;

    // Far above the slowest legal run: roughly 1000 ticks, each with random
    // idling on both sides, plus the long receiver hold-off.
    localparam int unsigned CYCLE_LIMIT = 400_000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_index   = CFG_TVOC_THRESHOLD;
    logic [15:0] i_cfg_data    = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = 24'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    int          pending;
    int          chk_errors;

    // Idle percentages of the two sides; the stimulus process changes them per phase.
    int          snd_idle   = 16;
    int          rcv_idle   = 68;
    // Toggling this asks the result sink for one long hold-off.
    logic        hold_req   = 1'b0;

    // Current register values, used only to shape the stimulus.
    logic [15:0] cur_thr    = RST_TVOC_THRESHOLD;
    logic [7:0]  cur_smp    = RST_BUTTON_SAMPLE;
    int          ticks_sent = 0;
    int unsigned cycle_cnt  = 0;

    always #10 i_clk = ~i_clk;

    fume_fan_mode_controller_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ffmc_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .o_pending   (pending),
        .o_errors    (chk_errors)
    );

    // Watchdog: a hung handshake or a result that never shows up ends here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result sink. It stalls at random, and when asked it holds tready low for a
    // long stretch so that the output and input registers both fill and the
    // block drops s_axis_tready while the sender keeps offering ticks.
    initial begin : result_sink
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    // Offers one tick transaction and returns at the edge that accepts it. The
    // valid is left high so that a following tick goes out back to back; it is
    // only lowered when a gap is actually inserted.
    task automatic send_tick(input logic level, input logic [15:0] tvoc);
        if ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, tvoc, level};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ticks_sent++;
    endtask

    // Stops offering ticks and waits until every predicted result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Registers are only written with no tick in flight.
    task automatic program_regs(input logic [15:0] thr, input logic [15:0] ext,
                                input logic [15:0] poll, input logic [7:0] smp);
        drain_results();
        write_reg(CFG_TVOC_THRESHOLD, thr);
        write_reg(CFG_EXTRACT_SECONDS, ext);
        write_reg(CFG_POLL_PERIOD_MS, poll);
        write_reg(CFG_BUTTON_SAMPLE, {8'd0, smp});
        i_cfg_we <= 1'b0;
        cur_thr  = thr;
        cur_smp  = smp;
    endtask

    // Most readings sit right around the threshold so that both comparisons
    // flip often; the rest are spread over the whole 16-bit range.
    function automatic logic [15:0] pick_tvoc(input logic [15:0] thr);
        int v;
        if ($urandom_range(9) < 4) begin
            return 16'($urandom);
        end
        v = int'(thr) + $urandom_range(4) - 2;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    // A clean button press at the current sample period: released samples, then
    // twelve to fifteen pressed samples, then release. With bounce set, some
    // pressed ticks read as released, which usually breaks the pattern.
    task automatic press_sequence(input logic bounce);
        int spt;
        int n;
        spt = (cur_smp == 8'd0) ? 1 : int'(cur_smp);
        n = $urandom_range(3, 1) * spt;
        repeat (n) send_tick(1'b0, pick_tvoc(cur_thr));
        n = $urandom_range(15, 12) * spt;
        for (int k = 0; k < n; k++) begin
            send_tick(!(bounce && $urandom_range(9) == 0), pick_tvoc(cur_thr));
        end
        n = $urandom_range(3, 1) * spt;
        repeat (n) send_tick(1'b0, pick_tvoc(cur_thr));
    endtask

    // Random traffic: presses, about a quarter with bounce, with random readings in
    // press_pct percent of the rounds, short bursts of random button noise otherwise.
    task automatic run_traffic(input int count, input int press_pct);
        int start;
        start = ticks_sent;
        while (ticks_sent - start < count) begin
            if ($urandom_range(99) < press_pct) begin
                press_sequence($urandom_range(3) == 0);
            end else begin
                repeat ($urandom_range(8, 1)) send_tick(1'($urandom), pick_tvoc(cur_thr));
            end
        end
    endtask

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: sampling and polling on every tick (zero periods).
        program_regs(16'd100, 16'd2, 16'd0, 8'd0);
        send_tick(1'b0, 16'hFFFF);                 // ready ignores the reading
        repeat (12) send_tick(1'b1, 16'h0000);     // press confirmed, ready to low
        send_tick(1'b0, 16'd100);                  // equal to threshold stays low
        send_tick(1'b0, 16'd101);                  // above threshold, high
        repeat (3) send_tick(1'b0, 16'd99);        // extract time runs out, back to low
        send_tick(1'b0, 16'hFFFF);                 // high again
        repeat (12) send_tick(1'b1, 16'($urandom)); // press while high, restart
        repeat (2) send_tick(1'b0, 16'd0);         // restart, then ready

        // Divider already past a newly lowered sample period.
        program_regs(16'd100, 16'd2, 16'd0, 8'd200);
        repeat (20) send_tick(1'b0, 16'($urandom));
        program_regs(16'd100, 16'd2, 16'd0, 8'd2);
        repeat (4) send_tick(1'b0, 16'($urandom));

        // Sender idles 16 percent, receiver 68 percent.
        snd_idle = 16;
        rcv_idle = 68;
        program_regs(16'd0, 16'd0, 16'd1, 8'd1);
        run_traffic(110, 70);
        drain_results();
        run_traffic(110, 70);
        program_regs(16'hFFFF, 16'hFFFF, 16'd2, 8'd2);
        run_traffic(110, 70);

        // Sender idles 68 percent, receiver 16 percent.
        snd_idle = 68;
        rcv_idle = 16;
        program_regs(16'd1000, 16'd3, 16'd4, 8'd0);
        run_traffic(140, 70);
        program_regs(16'd0, 16'hFFFF, 16'hFFFF, 8'd255);
        run_traffic(80, 0);

        // No idling on either side, with one long receiver hold-off in the middle.
        snd_idle = 0;
        rcv_idle = 0;
        program_regs(16'd500, 16'd1, 16'd0, 8'd3);
        run_traffic(80, 75);
        hold_req <= ~hold_req;
        run_traffic(140, 75);
        program_regs(16'($urandom_range(2000)), 16'($urandom_range(6)),
                     16'($urandom_range(6, 1)), 8'($urandom_range(3, 1)));
        run_traffic(110, 75);

        drain_results();
        if (chk_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
